[rtl/core/ascu_pkg.sv]
// ----------------------------------------------------------------------------
// ascu_pkg
// Shared types, constants and helpers for the ambient sensor compensation unit.
// ----------------------------------------------------------------------------
package ascu_pkg;

  localparam logic [31:0] PressOffset  = 32'd64000;
  localparam logic [31:0] PressBase    = 32'd1048576;
  localparam logic [31:0] PressScale   = 32'd3125;
  localparam logic [31:0] HumOffset    = 32'd76800;
  localparam logic [31:0] HumMax       = 32'd419430400;
  localparam logic [31:0] HumRound     = 32'd16384;
  localparam logic [31:0] HumBias      = 32'd2097152;
  localparam logic [31:0] HalfScale    = 32'd32768;
  localparam logic [31:0] HumRound2    = 32'd8192;

  localparam int          DivStages    = 32;

  // register indexes on the configuration port
  localparam logic [2:0] RegTempCalib  = 3'd0;
  localparam logic [2:0] RegPressLow   = 3'd1;
  localparam logic [2:0] RegPressHigh  = 3'd2;
  localparam logic [2:0] RegPressNinth = 3'd3;
  localparam logic [2:0] RegHumA       = 3'd4;
  localparam logic [2:0] RegHumB       = 3'd5;

  // calibration words, extended to 32 bits
  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
  } calib_t;

  // data that rides alongside the divider
  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
    logic        postmul;
    logic        pvalid;
  } div_side_t;

  function automatic logic [31:0] sra(input logic [31:0] x, input logic [4:0] n);
    logic signed [31:0] s;
    s = $signed(x);
    return s >>> n;
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic calib_t unpack_calib(input logic [47:0] tc, input logic [63:0] pl,
                                          input logic [63:0] ph, input logic [15:0] p9,
                                          input logic [39:0] ha, input logic [31:0] hb);
    calib_t c;
    c.t1 = {16'd0, tc[15:0]};
    c.t2 = sx16(tc[31:16]);
    c.t3 = sx16(tc[47:32]);
    c.p1 = {16'd0, pl[15:0]};
    c.p2 = sx16(pl[31:16]);
    c.p3 = sx16(pl[47:32]);
    c.p4 = sx16(pl[63:48]);
    c.p5 = sx16(ph[15:0]);
    c.p6 = sx16(ph[31:16]);
    c.p7 = sx16(ph[47:32]);
    c.p8 = sx16(ph[63:48]);
    c.p9 = sx16(p9);
    c.h1 = {24'd0, ha[7:0]};
    c.h2 = sx16(ha[23:8]);
    c.h3 = {24'd0, ha[31:24]};
    c.h6 = sx8(ha[39:32]);
    c.h4 = sx16(hb[15:0]);
    c.h5 = sx16(hb[31:16]);
    return c;
  endfunction

endpackage

[rtl/core/ascu_front.sv]
// ----------------------------------------------------------------------------
// ascu_front
// Fifteen-stage front end: temperature, pressure up to the divide, humidity.
// ----------------------------------------------------------------------------
module ascu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [19:0]         raw_temperature,
  input  logic [19:0]         raw_pressure,
  input  logic [15:0]         raw_humidity,
  input  ascu_pkg::calib_t    calib,
  output logic                div_valid,
  output logic [31:0]         div_num,
  output logic [31:0]         div_den,
  output ascu_pkg::div_side_t div_side
);
  import ascu_pkg::*;

  logic [14:0] v;

  logic [31:0] adc_t, x1, d1;
  logic [31:0] s1_m1, s1_dd, s1_p, s1_h;
  logic [31:0] s2_a, s2_m2, s2_p, s2_h;
  logic [31:0] s3_fine, s3_p, s3_h;
  logic [31:0] pa4;
  logic [31:0] s4_temp, s4_pa, s4_q, s4_dh, s4_p, s4_h;
  logic [31:0] s5_qq, s5_ap5, s5_p2a, s5_h5d, s5_dh6, s5_dh3, s5_temp, s5_p, s5_h;
  logic [31:0] s6_b6, s6_p3q, s6_ap5, s6_p2a, s6_ha, s6_hx, s6_hy, s6_temp, s6_p;
  logic [31:0] s7_b, s7_a, s7_hxy, s7_ha, s7_temp, s7_p;
  logic [31:0] s8_a2, s8_pt, s8_hb, s8_ha, s8_temp;
  logic [31:0] s9_den, s9_pm, s9_hbm, s9_ha, s9_temp;
  logic [31:0] s10_num, s10_den, s10_hb2, s10_ha, s10_temp;
  logic        s10_post;
  logic [31:0] s11_hd, s11_num, s11_den, s11_temp;
  logic        s11_post;
  logic [31:0] s12_s, s12_hd, s12_num, s12_den, s12_temp;
  logic        s12_post;
  logic [31:0] s13_ss, s13_hd, s13_num, s13_den, s13_temp;
  logic        s13_post;
  logic [31:0] s14_m, s14_hd, s14_num, s14_den, s14_temp;
  logic        s14_post;
  logic [31:0] r15;

  assign adc_t = 32'(raw_temperature);
  assign x1    = (adc_t >> 3) - (calib.t1 << 1);
  assign d1    = (adc_t >> 4) - calib.t1;
  assign pa4   = sra(s3_fine, 5'd1) - PressOffset;
  assign r15   = s14_hd - sra(s14_m, 5'd4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[13:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // temperature
    s1_m1 <= x1 * calib.t2;
    s1_dd <= d1 * d1;
    s1_p  <= 32'(raw_pressure);
    s1_h  <= 32'(raw_humidity);

    s2_a  <= sra(s1_m1, 5'd11);
    s2_m2 <= sra(s1_dd, 5'd12) * calib.t3;
    s2_p  <= s1_p;
    s2_h  <= s1_h;

    s3_fine <= s2_a + sra(s2_m2, 5'd14);
    s3_p    <= s2_p;
    s3_h    <= s2_h;

    s4_temp <= sra((s3_fine << 2) + s3_fine + 32'd128, 5'd8);
    s4_pa   <= pa4;
    s4_q    <= sra(pa4, 5'd2);
    s4_dh   <= s3_fine - HumOffset;
    s4_p    <= s3_p;
    s4_h    <= s3_h;

    // first products of pressure and humidity
    s5_qq   <= s4_q * s4_q;
    s5_ap5  <= s4_pa * calib.p5;
    s5_p2a  <= calib.p2 * s4_pa;
    s5_h5d  <= calib.h5 * s4_dh;
    s5_dh6  <= s4_dh * calib.h6;
    s5_dh3  <= s4_dh * calib.h3;
    s5_temp <= s4_temp;
    s5_p    <= s4_p;
    s5_h    <= s4_h;

    s6_b6   <= sra(s5_qq, 5'd11) * calib.p6;
    s6_p3q  <= calib.p3 * sra(s5_qq, 5'd13);
    s6_ap5  <= s5_ap5;
    s6_p2a  <= s5_p2a;
    s6_ha   <= sra((s5_h << 14) - (calib.h4 << 20) - s5_h5d + HumRound, 5'd15);
    s6_hx   <= sra(s5_dh6, 5'd10);
    s6_hy   <= sra(s5_dh3, 5'd11) + HalfScale;
    s6_temp <= s5_temp;
    s6_p    <= s5_p;

    s7_b    <= sra(s6_b6 + (s6_ap5 << 1), 5'd2) + (calib.p4 << 16);
    s7_a    <= sra(sra(s6_p3q, 5'd3) + sra(s6_p2a, 5'd1), 5'd18);
    s7_hxy  <= s6_hx * s6_hy;
    s7_ha   <= s6_ha;
    s7_temp <= s6_temp;
    s7_p    <= s6_p;

    s8_a2   <= (HalfScale + s7_a) * calib.p1;
    s8_pt   <= (PressBase - s7_p) - sra(s7_b, 5'd12);
    s8_hb   <= sra(s7_hxy, 5'd10) + HumBias;
    s8_ha   <= s7_ha;
    s8_temp <= s7_temp;

    s9_den  <= sra(s8_a2, 5'd15);
    s9_pm   <= s8_pt * PressScale;
    s9_hbm  <= s8_hb * calib.h2;
    s9_ha   <= s8_ha;
    s9_temp <= s8_temp;

    // large dividends are divided first and doubled afterwards
    s10_num  <= s9_pm[31] ? s9_pm : (s9_pm << 1);
    s10_post <= s9_pm[31];
    s10_den  <= s9_den;
    s10_hb2  <= sra(s9_hbm + HumRound2, 5'd14);
    s10_ha   <= s9_ha;
    s10_temp <= s9_temp;

    s11_hd   <= s10_ha * s10_hb2;
    s11_num  <= s10_num;
    s11_den  <= s10_den;
    s11_post <= s10_post;
    s11_temp <= s10_temp;

    s12_s    <= sra(s11_hd, 5'd15);
    s12_hd   <= s11_hd;
    s12_num  <= s11_num;
    s12_den  <= s11_den;
    s12_post <= s11_post;
    s12_temp <= s11_temp;

    s13_ss   <= s12_s * s12_s;
    s13_hd   <= s12_hd;
    s13_num  <= s12_num;
    s13_den  <= s12_den;
    s13_post <= s12_post;
    s13_temp <= s12_temp;

    s14_m    <= sra(s13_ss, 5'd7) * calib.h1;
    s14_hd   <= s13_hd;
    s14_num  <= s13_num;
    s14_den  <= s13_den;
    s14_post <= s13_post;
    s14_temp <= s13_temp;

    // output registers and humidity clamp
    div_num          <= s14_num;
    div_den          <= s14_den;
    div_side.temp    <= s14_temp;
    div_side.postmul <= s14_post;
    div_side.pvalid  <= (s14_den != '0);
    if (r15[31]) begin
      div_side.hum <= '0;
    end else if (r15 > HumMax) begin
      div_side.hum <= 17'(HumMax >> 12);
    end else begin
      div_side.hum <= 17'(r15 >> 12);
    end
  end

  assign div_valid = v[14];

endmodule

[rtl/core/ascu_div.sv]
// ----------------------------------------------------------------------------
// ascu_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ascu_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [31:0]         num,
  input  logic [31:0]         den,
  input  ascu_pkg::div_side_t in_side,
  output logic                out_valid,
  output logic [31:0]         quotient,
  output ascu_pkg::div_side_t out_side
);
  import ascu_pkg::*;

  logic [31:0] r_q [1:DivStages];
  logic [31:0] n_q [1:DivStages];
  logic [31:0] q_q [1:DivStages];
  logic [31:0] d_q [1:DivStages];
  div_side_t   s_q [1:DivStages];
  logic [DivStages:1] v_q;

  for (genvar i = 0; i < DivStages; i++) begin : g_stage
    logic [31:0] r_in, n_in, q_in, d_in;
    div_side_t   s_in;
    logic        v_in;
    logic [32:0] trial;
    logic [32:0] diff;

    if (i == 0) begin : g_first
      assign r_in = '0;
      assign n_in = num;
      assign q_in = '0;
      assign d_in = den;
      assign s_in = in_side;
      assign v_in = in_valid;
    end else begin : g_next
      assign r_in = r_q[i];
      assign n_in = n_q[i];
      assign q_in = q_q[i];
      assign d_in = d_q[i];
      assign s_in = s_q[i];
      assign v_in = v_q[i];
    end

    assign trial = {r_in, n_in[31]};
    assign diff  = trial - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      n_q[i+1] <= n_in << 1;
      d_q[i+1] <= d_in;
      s_q[i+1] <= s_in;
      if (trial >= {1'b0, d_in}) begin
        r_q[i+1] <= diff[31:0];
        q_q[i+1] <= {q_in[30:0], 1'b1};
      end else begin
        r_q[i+1] <= trial[31:0];
        q_q[i+1] <= {q_in[30:0], 1'b0};
      end
    end
  end

  assign out_valid = v_q[DivStages];
  assign quotient  = q_q[DivStages];
  assign out_side  = s_q[DivStages];

endmodule

[rtl/core/ascu_back.sv]
// ----------------------------------------------------------------------------
// ascu_back
// Three-stage back end: pressure correction after the divide, then the result register.
// ----------------------------------------------------------------------------
module ascu_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [31:0]         quotient,
  input  ascu_pkg::div_side_t in_side,
  input  ascu_pkg::calib_t    calib,
  output logic                done,
  output logic [31:0]         temperature_centi,
  output logic [31:0]         pressure_pa,
  output logic                pressure_valid,
  output logic [16:0]         humidity_q10
);
  import ascu_pkg::*;

  logic [1:0]  v;
  logic [31:0] press0;
  logic [31:0] b1_press, b1_pxx, b1_pb;
  div_side_t   b1_side;
  logic [31:0] b2_press, b2_m, b2_b;
  div_side_t   b2_side;

  assign press0 = in_side.postmul ? (quotient << 1) : quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      done <= 1'b0;
    end else begin
      v    <= {v[0], in_valid};
      done <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    b1_press <= press0;
    b1_pxx   <= (press0 >> 3) * (press0 >> 3);
    b1_pb    <= (press0 >> 2) * calib.p8;
    b1_side  <= in_side;

    b2_press <= b1_press;
    b2_m     <= calib.p9 * (b1_pxx >> 13);
    b2_b     <= sra(b1_pb, 5'd13);
    b2_side  <= b1_side;

    temperature_centi <= b2_side.temp;
    humidity_q10      <= b2_side.hum;
    pressure_valid    <= b2_side.pvalid;
    if (b2_side.pvalid) begin
      pressure_pa <= b2_press + sra(sra(b2_m, 5'd12) + b2_b + calib.p7, 5'd4);
    end else begin
      pressure_pa <= '0;
    end
  end

endmodule

[rtl/core/ambient_sensor_compensation_unit.sv]
// ----------------------------------------------------------------------------
// ambient_sensor_compensation_unit
// Integer calibration compensation of raw temperature, pressure and humidity.
// ----------------------------------------------------------------------------
// One item (a set of raw readings) is taken on every cycle that start is high;
// busy never rises. Each item's result appears 50 cycles later for one cycle,
// marked by done, and must be taken then. The latency is set by the 15-stage
// front end, the 32-stage one-bit-per-stage pressure divider and the 3-stage
// back end. Calibration registers sit at byte addresses 8*i on the APB port
// and must only be written while no item is in flight.
module ambient_sensor_compensation_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] raw_temperature,
  input  logic [19:0] raw_pressure,
  input  logic [15:0] raw_humidity,
  output logic        done,
  output logic [31:0] temperature_centi,
  output logic [31:0] pressure_pa,
  output logic        pressure_valid,
  output logic [16:0] humidity_q10,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import ascu_pkg::*;

  logic [47:0] temp_calib;
  logic [63:0] press_calib_low;
  logic [63:0] press_calib_high;
  logic [15:0] press_calib_ninth;
  logic [39:0] hum_calib_a;
  logic [31:0] hum_calib_b;
  logic [2:0]  reg_idx;
  logic        wr_en;
  calib_t      calib;

  logic        div_in_valid;
  logic [31:0] div_num, div_den;
  div_side_t   div_in_side;
  logic        div_out_valid;
  logic [31:0] quotient;
  div_side_t   div_out_side;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib        <= '0;
      press_calib_low   <= '0;
      press_calib_high  <= '0;
      press_calib_ninth <= '0;
      hum_calib_a       <= '0;
      hum_calib_b       <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        RegTempCalib:  temp_calib        <= pwdata[47:0];
        RegPressLow:   press_calib_low   <= pwdata;
        RegPressHigh:  press_calib_high  <= pwdata;
        RegPressNinth: press_calib_ninth <= pwdata[15:0];
        RegHumA:       hum_calib_a       <= pwdata[39:0];
        RegHumB:       hum_calib_b       <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegTempCalib:  prdata = {16'd0, temp_calib};
      RegPressLow:   prdata = press_calib_low;
      RegPressHigh:  prdata = press_calib_high;
      RegPressNinth: prdata = {48'd0, press_calib_ninth};
      RegHumA:       prdata = {24'd0, hum_calib_a};
      RegHumB:       prdata = {32'd0, hum_calib_b};
      default:       prdata = '0;
    endcase
  end

  assign calib = unpack_calib(temp_calib, press_calib_low, press_calib_high,
                              press_calib_ninth, hum_calib_a, hum_calib_b);

  ascu_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (start && !busy),
    .raw_temperature (raw_temperature),
    .raw_pressure    (raw_pressure),
    .raw_humidity    (raw_humidity),
    .calib           (calib),
    .div_valid       (div_in_valid),
    .div_num         (div_num),
    .div_den         (div_den),
    .div_side        (div_in_side)
  );

  ascu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_in_valid),
    .num       (div_num),
    .den       (div_den),
    .in_side   (div_in_side),
    .out_valid (div_out_valid),
    .quotient  (quotient),
    .out_side  (div_out_side)
  );

  ascu_back u_back (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (div_out_valid),
    .quotient          (quotient),
    .in_side           (div_out_side),
    .calib             (calib),
    .done              (done),
    .temperature_centi (temperature_centi),
    .pressure_pa       (pressure_pa),
    .pressure_valid    (pressure_valid),
    .humidity_q10      (humidity_q10)
  );

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && !pressure_valid |-> pressure_pa == '0)
    else $error("invalid pressure item not zeroed");

  a_hum_clamp: assert property (@(posedge clk) disable iff (rst)
    done |-> humidity_q10 <= 17'd102400)
    else $error("humidity item out of clamp range");

  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe right after reset");

  a_div_align: assert property (@(posedge clk) disable iff (rst)
    div_out_valid |=> ##2 done)
    else $error("divider item lost in back end");
`endif

endmodule
